FILE: src/gfba_pkg.sv
// gfba_pkg: shared types and constants for the grouped free-block allocator.
// Holds the result status codes and the controller/datapath command and status words.
// No dependencies.
`default_nettype none

package gfba_pkg;

  // result status codes
  localparam logic [1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_FREED     = 2'd2;
  localparam logic [1:0] STAT_IGNORED   = 2'd3;

  // request codes on in_func
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;     // clearing pass: write one group's fill word
    logic accept;      // latch request, run group search, read fill word
    logic meta_step;   // update fill word, push or start pop
    logic entry_step;  // pop data is back, emit result
  } gfba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;   // clearing pass is on its last group
    logic need_entry;  // current request is a pop that reads the entry store
  } gfba_sts_t;

endpackage

`default_nettype wire

FILE: src/gfba_ctrl.sv
// gfba_ctrl: sequencing state machine of the allocator.
// Depends on gfba_pkg (command and status words).
`default_nettype none

module gfba_ctrl
  import gfba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  gfba_sts_t      sts,
  output gfba_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_META,
    S_ENTRY
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (sts.init_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_META;
      S_META:  state_nxt = sts.need_entry ? S_ENTRY : S_IDLE;
      S_ENTRY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy           = busy_r;
  assign cmd.init_wr    = (state_r == S_INIT);
  assign cmd.accept     = (state_r == S_IDLE) && start;
  assign cmd.meta_step  = (state_r == S_META);
  assign cmd.entry_step = (state_r == S_ENTRY);

endmodule

`default_nettype wire

FILE: src/gfba_datapath.sv
// gfba_datapath: group search, fill-word memory, entry memory and result register.
// Depends on gfba_pkg (status codes, command and status words).
`default_nettype none

module gfba_datapath
  import gfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 256,
  parameter int GROUP_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  gfba_cmd_t       cmd,
  output gfba_sts_t       sts,
  input  wire logic       in_func,
  input  wire logic [7:0] in_block_number,
  output logic            out_valid,
  output logic [7:0]      out_granted_block,
  output logic [1:0]      out_status
);

  localparam int NG        = (NUM_BLOCKS + GROUP_DEPTH - 1) / GROUP_DEPTH;
  localparam int GW        = (NG > 1) ? $clog2(NG) : 1;
  localparam int SW        = $clog2(GROUP_DEPTH);
  localparam int FW        = $clog2(GROUP_DEPTH + 1);
  localparam int EW        = $clog2(NUM_BLOCKS);
  localparam int AW        = GW + SW;
  localparam int MD        = NG << SW;
  localparam int LAST_FILL = (NUM_BLOCKS - 1) - (NG - 1) * GROUP_DEPTH;

  localparam logic [NG-1:0] ALL_ONES     = '1;
  localparam logic [NG-1:0] LAST_BIT     = NG'(1) << (NG - 1);
  localparam logic [NG-1:0] NONEMPTY_RST = (LAST_FILL == 0) ? ~LAST_BIT : ALL_ONES;
  localparam logic [NG-1:0] NOTFULL_RST  = (LAST_FILL < GROUP_DEPTH) ? LAST_BIT : '0;
  localparam logic [FW-1:0] FILL_FULL    = FW'(GROUP_DEPTH);
  localparam logic [FW-1:0] FILL_LAST    = FW'(LAST_FILL);
  localparam logic [GW-1:0] GRP_LAST     = GW'(NG - 1);

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_EXHAUST,
    KIND_FREE,
    KIND_IGNORE
  } kind_t;

  // lowest set bit: {found, index}
  function automatic logic [GW:0] first_set(input logic [NG-1:0] v);
    logic [GW:0] r;
    r = '0;
    for (int i = NG - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, GW'(i)};
    end
    return r;
  endfunction

  // per-group summary bits, kept in flops so the search is combinational
  logic [NG-1:0] nonempty_r, notfull_r;
  logic [GW-1:0] active_r, active_nxt;
  logic          exh_r, exh_nxt;
  logic [GW-1:0] init_cnt_r;

  kind_t         kind_r, kind_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic [7:0]    blk_r;

  // fill word: {low-water mark, fill}
  logic [2*FW-1:0] meta_mem [0:NG-1];
  logic [2*FW-1:0] meta_q;
  logic            meta_we;
  logic [GW-1:0]   meta_wa;
  logic [2*FW-1:0] meta_wd;
  logic [FW-1:0]   fill, lw, fill_dec, fill_inc, lw_dec, init_val;

  logic [EW-1:0] ent_mem [0:MD-1];
  logic [EW-1:0] entry_q;
  logic [SW-1:0] slot_r;
  logic          pristine_r;
  logic [AW:0]   rst_val;

  logic          out_valid_r;
  logic [7:0]    out_blk_r;
  logic [1:0]    out_stat_r;

  logic [GW:0]   alloc_hit, free_fwd, free_any;
  logic [GW-1:0] free_base;
  logic          blk_ok;

  // search and decision, evaluated in the accept cycle
  always_comb begin
    free_base = exh_r ? '0 : active_r;
    alloc_hit = first_set(nonempty_r & (ALL_ONES << active_r));
    free_fwd  = first_set(notfull_r & (ALL_ONES << free_base));
    free_any  = first_set(notfull_r);
    blk_ok    = (in_block_number != 8'd0) && (32'(in_block_number) < NUM_BLOCKS);

    kind_nxt   = KIND_IGNORE;
    grp_nxt    = '0;
    active_nxt = active_r;
    exh_nxt    = exh_r;
    if (in_func == FUNC_ALLOC) begin
      if (!exh_r && alloc_hit[GW]) begin
        kind_nxt   = KIND_ALLOC;
        grp_nxt    = alloc_hit[GW-1:0];
        active_nxt = alloc_hit[GW-1:0];
      end else begin
        kind_nxt   = KIND_EXHAUST;
        active_nxt = '0;
        exh_nxt    = 1'b1;
      end
    end else if (blk_ok) begin
      exh_nxt    = 1'b0;
      active_nxt = free_base;
      if (free_fwd[GW]) begin
        kind_nxt = KIND_FREE;
        grp_nxt  = free_fwd[GW-1:0];
      end else if (free_any[GW]) begin
        kind_nxt = KIND_FREE;
        grp_nxt  = free_any[GW-1:0];
        if (free_any[GW-1:0] < free_base) active_nxt = free_any[GW-1:0];
      end
    end
  end

  // fill-word update
  always_comb begin
    {lw, fill} = meta_q;
    fill_dec   = fill - FW'(1);
    fill_inc   = fill + FW'(1);
    lw_dec     = (fill_dec < lw) ? fill_dec : lw;
    init_val   = (init_cnt_r == GRP_LAST) ? FILL_LAST : FILL_FULL;
    meta_we    = 1'b0;
    meta_wa    = grp_r;
    meta_wd    = meta_q;
    if (cmd.init_wr) begin
      meta_we = 1'b1;
      meta_wa = init_cnt_r;
      meta_wd = {init_val, init_val};
    end else if (cmd.meta_step && kind_r == KIND_ALLOC) begin
      meta_we = 1'b1;
      meta_wd = {lw_dec, fill_dec};
    end else if (cmd.meta_step && kind_r == KIND_FREE) begin
      meta_we = 1'b1;
      meta_wd = {lw, fill_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (cmd.accept) meta_q <= meta_mem[grp_nxt];
  end

  // entry store; a slot at or above the low-water mark has been rewritten
  always_ff @(posedge clk) begin
    if (cmd.meta_step && kind_r == KIND_FREE)
      ent_mem[{grp_r, fill[SW-1:0]}] <= EW'(blk_r);
    if (cmd.meta_step && kind_r == KIND_ALLOC) begin
      entry_q    <= ent_mem[{grp_r, fill_dec[SW-1:0]}];
      slot_r     <= fill_dec[SW-1:0];
      pristine_r <= (lw == fill);
    end
  end

  assign rst_val = (AW+1)'(grp_r) * (AW+1)'(GROUP_DEPTH) + (AW+1)'(slot_r) + (AW+1)'(1);

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind_nxt;
      grp_r  <= grp_nxt;
      blk_r  <= in_block_number;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= NONEMPTY_RST;
      notfull_r   <= NOTFULL_RST;
      active_r    <= '0;
      exh_r       <= 1'b0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr && init_cnt_r != GRP_LAST) init_cnt_r <= init_cnt_r + GW'(1);
      if (cmd.accept) begin
        active_r <= active_nxt;
        exh_r    <= exh_nxt;
      end
      if (cmd.meta_step && kind_r == KIND_ALLOC) begin
        nonempty_r[grp_r] <= (fill_dec != '0);
        notfull_r[grp_r]  <= 1'b1;
      end else if (cmd.meta_step && kind_r == KIND_FREE) begin
        nonempty_r[grp_r] <= 1'b1;
        notfull_r[grp_r]  <= (fill_inc != FILL_FULL);
      end
      out_valid_r <= (cmd.meta_step && kind_r != KIND_ALLOC) || cmd.entry_step;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.entry_step) begin
      out_blk_r  <= pristine_r ? 8'(rst_val) : 8'(entry_q);
      out_stat_r <= STAT_ALLOCATED;
    end else if (cmd.meta_step) begin
      out_blk_r <= 8'd0;
      case (kind_r)
        KIND_EXHAUST: out_stat_r <= STAT_EXHAUSTED;
        KIND_FREE:    out_stat_r <= STAT_FREED;
        KIND_IGNORE:  out_stat_r <= STAT_IGNORED;
        default:      out_stat_r <= STAT_ALLOCATED;
      endcase
    end
  end

  assign sts.init_last      = (init_cnt_r == GRP_LAST);
  assign sts.need_entry     = (kind_r == KIND_ALLOC);
  assign out_valid          = out_valid_r;
  assign out_granted_block  = out_blk_r;
  assign out_status         = out_stat_r;

endmodule

`default_nettype wire

FILE: src/grouped_free_block_allocator.sv
// grouped_free_block_allocator: top level, joins the controller and the datapath.
// Depends on gfba_pkg, gfba_ctrl, gfba_datapath.
//
// Usage:
//   Request word: in_func (0 allocate, 1 free) and in_block_number. A word is
//   taken at a rising edge with start high and busy low.
//   Result word: out_granted_block and out_status, shown for exactly one cycle
//   with out_valid high. The receiver cannot stall; every request gives one
//   result word.
// Request sequence:
//   Free, ignored free and exhausted allocate: out_valid rises after the
//   fill-update state; a new word can be taken in the cycle out_valid is high.
//   Allocate with a hit: the entry state, for the registered read of the entry
//   memory, follows the fill-update state before out_valid rises. The group
//   search is combinational over per-group summary flops; the fill-word memory
//   read feeds the fill-update state, the entry memory read the entry state.
// Reset:
//   rst_n is synchronous, active low. After release a clearing pass writes the
//   reset fill word of every group (16 by default), one group per cycle; busy
//   is high meanwhile.
//   Entry memory is never swept: a slot not rewritten since reset is detected
//   by a per-group low-water mark and reads as its reset block number.
`default_nettype none

module grouped_free_block_allocator
  import gfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 256,
  parameter int GROUP_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_func,
  input  wire logic [7:0] in_block_number,
  output logic            out_valid,
  output logic [7:0]      out_granted_block,
  output logic [1:0]      out_status
);

  gfba_cmd_t cmd;
  gfba_sts_t sts;

  // sequencer: clearing pass, accept, fill update, entry read
  gfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // search, memories and result register
  gfba_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .GROUP_DEPTH (GROUP_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire

FILE: src/gfba_checker.sv
// gfba_port_checks: port-level assertions for the allocator, bound to the top level.
// Depends on gfba_pkg (status and request codes).
`default_nettype none

module gfba_port_checks
  import gfba_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_func,
  input wire logic [7:0] in_block_number,
  input wire logic       out_valid,
  input wire logic [7:0] out_granted_block,
  input wire logic [1:0] out_status
);

  // no two result strobes are back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // the block is ready again when it shows a result
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while showing a result");

  // only a successful allocate carries a block number
  a_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_ALLOCATED) |-> (out_granted_block == 8'd0))
    else $error("nonzero block on a non-allocate result");

  // a free is answered with freed or ignored
  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_FREE) |-> ##2
      (out_valid && (out_status == STAT_FREED || out_status == STAT_IGNORED)))
    else $error("free request without freed or ignored result");

endmodule

bind grouped_free_block_allocator gfba_port_checks u_port_checks (.*);

`default_nettype wire

FILE: verif/gfba_checker.sv
// gfba_checker: watches the request and result channels of the allocator,
// predicts each result word from a private copy of the group stacks and compares.
// Depends on gfba_pkg for the request and status codes.

module gfba_checker
  import gfba_pkg::*;
#(
  parameter int BLOCK_COUNT = 256,
  parameter int GROUP_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_func,
  input  logic [7:0] in_block_number,
  input  logic       out_valid,
  input  logic [7:0] out_granted_block,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending
);

  localparam int GROUPS = (BLOCK_COUNT + GROUP_DEPTH - 1) / GROUP_DEPTH;

  typedef struct packed {
    logic [7:0] granted;
    logic [1:0] status;
  } grant_word_t;

  logic [4:0] group_fill [GROUPS];
  logic [7:0] slot_block [GROUPS][GROUP_DEPTH];
  logic [3:0] active_group;
  logic       chain_exhausted;

  grant_word_t grant_queue[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("gfba_checker: %s: got %0d, expected %0d (t=%0t)", what, got_v, want_v, $time);
    fail_count++;
  endtask

  task automatic reset_stacks();
    for (int g = 0; g < GROUPS; g++) begin
      group_fill[g] = '0;
      for (int k = 0; k < GROUP_DEPTH; k++)
        slot_block[g][k] = 8'(g * GROUP_DEPTH + k + 1);
    end
    for (int b = 1; b < BLOCK_COUNT; b++)
      group_fill[(b - 1) / GROUP_DEPTH]++;
    active_group    = '0;
    chain_exhausted = 1'b0;
  endtask

  // One request against the stacks; returns the result word it produces.
  task automatic apply_request(input logic func, input logic [7:0] blk,
                               output grant_word_t word);
    int  tgt;
    bit  hit;
    tgt     = -1;
    hit     = 0;
    word    = '{granted: 8'd0, status: STAT_IGNORED};
    if (func == FUNC_ALLOC) begin
      if (!chain_exhausted) begin
        for (int g = int'(active_group); g < GROUPS; g++) begin
          if (!hit && group_fill[g] != 0) begin
            hit = 1;
            group_fill[g]--;
            active_group = 4'(g);
            word = '{granted: slot_block[g][group_fill[g]], status: STAT_ALLOCATED};
          end
        end
      end
      if (!hit) begin
        chain_exhausted = 1'b1;
        active_group    = '0;
        word = '{granted: 8'd0, status: STAT_EXHAUSTED};
      end
    end else if (blk != 0 && int'(blk) < BLOCK_COUNT) begin
      if (chain_exhausted) begin
        chain_exhausted = 1'b0;
        active_group    = '0;
      end
      // forward from the active group, then wrap to group 0
      for (int g = int'(active_group); g < GROUPS; g++)
        if (tgt < 0 && group_fill[g] < GROUP_DEPTH) tgt = g;
      for (int g = 0; g < GROUPS; g++)
        if (tgt < 0 && group_fill[g] < GROUP_DEPTH) tgt = g;
      if (tgt >= 0) begin
        slot_block[tgt][group_fill[tgt]] = blk;
        group_fill[tgt]++;
        if (tgt < int'(active_group)) active_group = 4'(tgt);
        word = '{granted: 8'd0, status: STAT_FREED};
      end
    end
  endtask

  always @(posedge clk) begin : watch
    grant_word_t want;
    grant_word_t got;
    if (!rst_n) begin
      reset_stacks();
      grant_queue.delete();
    end else begin
      // result first: it always belongs to an earlier request
      if (out_valid) begin
        if (grant_queue.size() == 0) begin
          report_mismatch("result word with no request waiting", out_status, -1);
        end else begin
          want = grant_queue.pop_front();
          if (out_granted_block !== want.granted)
            report_mismatch("out_granted_block", out_granted_block, want.granted);
          if (out_status !== want.status)
            report_mismatch("out_status", out_status, want.status);
        end
      end
      if (start && !busy) begin
        apply_request(in_func, in_block_number, got);
        grant_queue.push_back(got);
      end
    end
    pending = grant_queue.size();
  end

endmodule

FILE: verif/grouped_free_block_allocator_tb.sv
// grouped_free_block_allocator_tb: stimulus and verdict for the allocator.
// Depends on gfba_pkg, grouped_free_block_allocator and gfba_checker.
// Directed requests first, then phased random traffic that drains and refills.

module grouped_free_block_allocator_tb;
  import gfba_pkg::*;

  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT  = 60000;  // far above what the slowest run needs
  localparam int TAIL_CYCLES  = 4;      // margin for the slowest request, an allocate hit

  typedef enum {PH_DRAIN, PH_REFILL, PH_MIXED} traffic_phase_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_func;
  logic [7:0] in_block_number;
  logic       out_valid;
  logic [7:0] out_granted_block;
  logic [1:0] out_status;

  int fail_count;
  int pending;
  int cycle_count;
  int exhausted_seen;

  // blocks handed out and not yet returned; frees are mostly drawn from here
  logic [7:0] held_blocks[$];

  grouped_free_block_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_granted_block(out_granted_block),
    .out_status       (out_status)
  );

  gfba_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_granted_block(out_granted_block),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog; also covers a result word that never shows up
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grouped_free_block_allocator_tb: FAIL");
      $finish;
    end
  end

  // Track grants so the stimulus can hand real blocks back, and count
  // exhausted answers so the drain phase knows when it hit the bottom.
  initial exhausted_seen = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (out_status == STAT_ALLOCATED) held_blocks.push_back(out_granted_block);
      if (out_status == STAT_EXHAUSTED) exhausted_seen++;
    end
  end

  // Called at a rising edge. Presents one word and returns at the edge that
  // takes it. busy only moves at edges, so the falling edge gives a clean look.
  task automatic send_word(input logic func, input logic [7:0] blk);
    start           <= 1'b1;
    in_func         <= func;
    in_block_number <= blk;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Drop start and wait out the given idle stretch; the payload ports carry junk meanwhile.
  task automatic idle_cycles(input int n);
    start           <= 1'b0;
    in_func         <= 1'($urandom);
    in_block_number <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Mostly a block we know is out; otherwise anything, zero included.
  function automatic logic [7:0] pick_free_block();
    int idx;
    logic [7:0] blk;
    if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, held_blocks.size() - 1);
      blk = held_blocks[idx];
      held_blocks.delete(idx);
    end else if ($urandom_range(0, 7) == 0) begin
      blk = 8'd0;
    end else begin
      blk = 8'($urandom_range(0, 255));
    end
    return blk;
  endfunction

  initial begin : stimulus
    traffic_phase_t phase;
    int  phase_left;
    int  exhausted_mark;
    int  drain_tail;
    int  burst_left;
    int  gap;
    bit  is_free;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = FUNC_ALLOC;
    in_block_number = 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: first pops, ignored and pushed frees, full chain ---
    send_word(FUNC_ALLOC, 8'd0);
    send_word(FUNC_ALLOC, 8'd0);
    send_word(FUNC_FREE,  8'd0);     // block zero is ignored
    send_word(FUNC_FREE,  8'd255);   // top block number goes back on group 0
    send_word(FUNC_ALLOC, 8'd0);
    send_word(FUNC_FREE,  8'd16);
    send_word(FUNC_FREE,  8'd15);    // group 0 full again
    send_word(FUNC_FREE,  8'd1);     // double free lands on the last group
    send_word(FUNC_FREE,  8'd128);   // every group full: ignored
    send_word(FUNC_FREE,  8'd255);
    send_word(FUNC_ALLOC, 8'hff);    // block field ignored on allocate
    send_word(FUNC_FREE,  8'haa);
    send_word(FUNC_FREE,  8'h55);
    send_word(FUNC_ALLOC, 8'h55);
    send_word(FUNC_ALLOC, 8'haa);
    idle_cycles(3);
    held_blocks.delete();            // directed grants were handled above

    // --- random: drain to exhaustion, refill, mix, repeat ---
    phase          = PH_DRAIN;
    phase_left     = 0;
    drain_tail     = -1;
    exhausted_mark = exhausted_seen;
    burst_left     = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) idle_cycles(gap);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;

      case (phase)
        PH_DRAIN: begin
          is_free = ($urandom_range(0, 99) >= 93);
          // once the chain runs dry, a few more allocates, then refill
          if (drain_tail < 0 && exhausted_seen != exhausted_mark)
            drain_tail = $urandom_range(2, 5);
          if (drain_tail > 0) begin
            is_free = 1'b0;
            drain_tail--;
          end else if (drain_tail == 0) begin
            phase      = PH_REFILL;
            phase_left = $urandom_range(60, 140);
            drain_tail = -1;
          end
        end
        PH_REFILL: begin
          is_free = ($urandom_range(0, 99) < 85);
          phase_left--;
          if (phase_left == 0) begin
            phase      = PH_MIXED;
            phase_left = $urandom_range(60, 120);
          end
        end
        default: begin
          is_free = 1'($urandom_range(0, 1));
          phase_left--;
          if (phase_left == 0) begin
            phase          = PH_DRAIN;
            exhausted_mark = exhausted_seen;
          end
        end
      endcase

      if (is_free) send_word(FUNC_FREE, pick_free_block());
      else         send_word(FUNC_ALLOC, 8'($urandom));
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("grouped_free_block_allocator_tb: PASS");
    end else begin
      $display("grouped_free_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/gfba_pkg.sv
src/gfba_ctrl.sv
src/gfba_datapath.sv
src/grouped_free_block_allocator.sv
src/gfba_checker.sv
verif/gfba_checker.sv
verif/grouped_free_block_allocator_tb.sv
